>>> rtl/ftrl_pkg.sv
// Shared widths, register indexes and reset values for the FTRL weight update block.
package ftrl_pkg;

  localparam int FRAC          = 16;
  localparam int NUM_WEIGHTS_DEF = 4096;

  localparam int IDX_W   = 12;
  localparam int DATA_W  = 32;
  localparam int Z_W     = 40;
  localparam int N_W     = 48;
  localparam int ROOT_W  = 32;
  localparam int DVD_W   = 56;
  localparam int DVS_W   = 50;
  localparam int MA_W    = 48;
  localparam int MB_W    = 32;
  localparam int PROD_W  = MA_W + MB_W;

  typedef enum logic [1:0] {
    REG_ALPHA = 2'd0,
    REG_BETA  = 2'd1,
    REG_L1    = 2'd2,
    REG_L2    = 2'd3
  } reg_idx_t;

  localparam logic [DATA_W-1:0] ALPHA_RST = 32'd65536;
  localparam logic [DATA_W-1:0] BETA_RST  = 32'd65536;
  localparam logic [DATA_W-1:0] L1_RST    = 32'd66;
  localparam logic [DATA_W-1:0] L2_RST    = 32'd66;

endpackage

>>> rtl/ftrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ftrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ftrl_sqrt.sv
// Digit-serial square root, two radicand bits per cycle: root = floor(sqrt(x * 2^FRAC)).
module ftrl_sqrt import ftrl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [N_W-1:0]    x,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fit;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fit    = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= {x, {FRAC{1'b0}}};
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= fit ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], fit};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> rtl/ftrl_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module ftrl_div import ftrl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic             fit;
  logic [DVS_W:0]   rem_sub;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign fit     = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], fit};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

>>> rtl/ftrl_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, full-width product.
module ftrl_mul import ftrl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MA_W-1:0]   a,
  input  logic [MB_W-1:0]   b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic [MA_W-1:0] a_r;
  logic [MA_W-1:0] hi_r;
  logic [MB_W-1:0] lo_r;
  logic [4:0]      cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [MA_W:0]   sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= a;
        hi_r   <= '0;
        lo_r   <= b;
      end else if (busy_r) begin
        hi_r  <= sum[MA_W:1];
        lo_r  <= {sum[0], lo_r[MB_W-1:1]};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(MB_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

>>> rtl/ftrl_proximal_weight_update.sv
// FTRL-Proximal weight update top level: sequencer, accumulator RAMs and shared serial units.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_wdata
//   in       in         in_valid/in_ready    in_weight_index, in_gradient_value, in_current_weight
//   out      out        out_valid/out_ready  out_new_weight, out_delta_weight, out_weight_zeroed
//
// One item at a time: an index reduction, two 32-step multiplies, two 32-step square
// roots and up to three 56-step divisions, all on one shared unit of each kind. Fewer
// divisions run when the weight is zeroed or when the denominator is zero.
// After reset a clearing pass zeroes both accumulator RAMs; no item is accepted until
// it ends. A waiting result stalls only the final load.
module ftrl_proximal_weight_update import ftrl_pkg::*; #(
  parameter int NUM_WEIGHTS = NUM_WEIGHTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IDX_W-1:0]         in_weight_index,
  input  logic signed [DATA_W-1:0] in_gradient_value,
  input  logic signed [DATA_W-1:0] in_current_weight,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_new_weight,
  output logic signed [DATA_W-1:0] out_delta_weight,
  output logic                     out_weight_zeroed
);

  localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
  localparam int RW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_MOD   = 14'b00000000000100,
    S_READ  = 14'b00000000001000,
    S_LOAD  = 14'b00000000010000,
    S_MULG  = 14'b00000000100000,
    S_SQO   = 14'b00000001000000,
    S_SQN   = 14'b00000010000000,
    S_DSIG  = 14'b00000100000000,
    S_MULT  = 14'b00001000000000,
    S_ZUPD  = 14'b00010000000000,
    S_DDEN  = 14'b00100000000000,
    S_DMAG  = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [DATA_W-1:0] alpha_r, beta_r, l1_r, l2_r;
  logic [DATA_W-1:0] alpha_eff;

  logic [AW-1:0]     clr_r;
  logic [IDX_W-1:0]  idx_in_r;
  logic [RW-1:0]     mod_rem_r;
  logic [3:0]        mod_cnt_r;
  logic [RW-1:0]     mod_sh;
  logic [RW-1:0]     mod_nxt;

  logic signed [DATA_W-1:0] g_r, w_r;
  logic [DATA_W-1:0] gm_r, wm_r;
  logic [Z_W-1:0]    z_old_r, z_new_r, zm_r;
  logic [N_W-1:0]    n_old_r, n_new_r;
  logic [ROOT_W-1:0] s_old_r, s_new_r;
  logic [MA_W-1:0]   sigma_r;
  logic [41:0]       t_r;
  logic [DVS_W-1:0]  den_r;
  logic [32:0]       mag_r;
  logic              zeroed_r;
  logic              started_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_nw_r, out_dw_r;
  logic              out_zero_r;

  logic              sq_start, sq_done;
  logic [N_W-1:0]    sq_x;
  logic [ROOT_W-1:0] sq_root;
  logic              dv_start, dv_done;
  logic [DVD_W-1:0]  dv_dvd, dv_q;
  logic [DVS_W-1:0]  dv_dvs;
  logic              ml_start, ml_done;
  logic [MA_W-1:0]   ml_a;
  logic [MB_W-1:0]   ml_b;
  logic [PROD_W-1:0] ml_prod;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [Z_W-1:0]    z_wdata, z_rdata;
  logic [N_W-1:0]    n_wdata, n_rdata;

  logic [63:0]       g2_sum;
  logic [N_W:0]      n_sum;
  logic [63:0]       t_full;
  logic [43:0]       z_sum;
  logic [43:0]       t_adj;
  logic [Z_W-1:0]    z_sat;
  logic [Z_W-1:0]    z_mag;
  logic              z_zeroed;
  logic              w_pos, w_neg, z_pos;
  logic [33:0]       nw_wide;
  logic [DATA_W-1:0] nw_sat;
  logic [33:0]       dw_wide;
  logic [DATA_W-1:0] dw_sat;
  logic              unit_done;
  logic              in_fire, fin_load;

  assign alpha_eff = (alpha_r == '0) ? 32'd1 : alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      beta_r  <= BETA_RST;
      l1_r    <= L1_RST;
      l2_r    <= L2_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ALPHA: alpha_r <= cfg_wdata;
        REG_BETA:  beta_r  <= cfg_wdata;
        REG_L1:    l1_r    <= cfg_wdata;
        REG_L2:    l2_r    <= cfg_wdata;
        default:   alpha_r <= alpha_r;
      endcase
    end
  end

  assign mod_sh  = {mod_rem_r[RW-2:0], idx_in_r[IDX_W-1]};
  assign mod_nxt = (mod_sh >= RW'(NUM_WEIGHTS)) ? (mod_sh - RW'(NUM_WEIGHTS)) : mod_sh;

  assign w_pos = !w_r[DATA_W-1] && (w_r != '0);
  assign w_neg = w_r[DATA_W-1];
  assign z_pos = !z_new_r[Z_W-1] && (z_new_r != '0);

  assign g2_sum = ml_prod[63:0] + 64'd32768;
  assign n_sum  = {1'b0, n_old_r} + {1'b0, g2_sum[63:FRAC]};
  assign t_full = ml_prod[PROD_W-1:FRAC];

  assign t_adj = w_pos ? (~{2'b00, t_r} + 44'd1) : (w_neg ? {2'b00, t_r} : '0);
  assign z_sum = {{4{z_old_r[Z_W-1]}}, z_old_r} + {{12{g_r[DATA_W-1]}}, g_r} + t_adj;

  always_comb begin
    if (!z_sum[43] && (z_sum[42:39] != 4'h0)) begin
      z_sat = {1'b0, {(Z_W-1){1'b1}}};
    end else if (z_sum[43] && (z_sum[42:39] != 4'hF)) begin
      z_sat = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      z_sat = z_sum[Z_W-1:0];
    end
  end

  assign z_mag    = z_sat[Z_W-1] ? (~z_sat + 40'd1) : z_sat;
  assign z_zeroed = !(z_mag > {8'h00, l1_r});

  assign nw_wide = z_pos ? (~{1'b0, mag_r} + 34'd1) : {1'b0, mag_r};
  always_comb begin
    if (zeroed_r) begin
      nw_sat = '0;
    end else if (!nw_wide[33] && (nw_wide[32:31] != 2'b00)) begin
      nw_sat = 32'h7FFF_FFFF;
    end else if (nw_wide[33] && (nw_wide[32:31] != 2'b11)) begin
      nw_sat = 32'h8000_0000;
    end else begin
      nw_sat = nw_wide[31:0];
    end
  end

  assign dw_wide = {{2{nw_sat[31]}}, nw_sat} - {{2{w_r[31]}}, w_r};
  always_comb begin
    if (!dw_wide[33] && (dw_wide[32:31] != 2'b00)) begin
      dw_sat = 32'h7FFF_FFFF;
    end else if (dw_wide[33] && (dw_wide[32:31] != 2'b11)) begin
      dw_sat = 32'h8000_0000;
    end else begin
      dw_sat = dw_wide[31:0];
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    case (state_r)
      S_MULG, S_MULT:         unit_done = ml_done;
      S_SQO, S_SQN:           unit_done = sq_done;
      S_DSIG, S_DDEN, S_DMAG: unit_done = dv_done;
      default:                unit_done = 1'b0;
    endcase
  end

  assign ml_start = ((state_r == S_MULG) || (state_r == S_MULT)) && !started_r;
  assign ml_a     = (state_r == S_MULG) ? {16'h0000, gm_r} : sigma_r;
  assign ml_b     = (state_r == S_MULG) ? gm_r : wm_r;

  assign sq_start = ((state_r == S_SQO) || (state_r == S_SQN)) && !started_r;
  assign sq_x     = (state_r == S_SQO) ? n_old_r : n_new_r;

  assign dv_start = ((state_r == S_DSIG) || (state_r == S_DDEN) ||
                     ((state_r == S_DMAG) && (den_r != '0))) && !started_r;

  always_comb begin
    case (state_r)
      S_DSIG: begin
        dv_dvd = {8'h00, s_new_r - s_old_r, {FRAC{1'b0}}};
        dv_dvs = {18'h00000, alpha_eff};
      end
      S_DDEN: begin
        dv_dvd = {7'h00, {1'b0, beta_r} + {1'b0, s_new_r}, {FRAC{1'b0}}};
        dv_dvs = {18'h00000, alpha_eff};
      end
      default: begin
        dv_dvd = {zm_r - {8'h00, l1_r}, {FRAC{1'b0}}};
        dv_dvs = den_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == AW'(NUM_WEIGHTS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_MOD;
      S_MOD:   if (mod_cnt_r == 4'(IDX_W - 1)) state_nxt = S_READ;
      S_READ:  state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_MULG;
      S_MULG:  if (unit_done) state_nxt = S_SQO;
      S_SQO:   if (unit_done) state_nxt = S_SQN;
      S_SQN:   if (unit_done) state_nxt = S_DSIG;
      S_DSIG:  if (unit_done) state_nxt = S_MULT;
      S_MULT:  if (unit_done) state_nxt = S_ZUPD;
      S_ZUPD:  state_nxt = z_zeroed ? S_FIN : S_DDEN;
      S_DDEN:  if (unit_done) state_nxt = S_DMAG;
      S_DMAG:  if (unit_done || (den_r == '0)) state_nxt = S_FIN;
      S_FIN:   if (fin_load) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (unit_done) begin
        started_r <= 1'b0;
      end else if (ml_start || sq_start || dv_start) begin
        started_r <= 1'b1;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          idx_in_r  <= in_weight_index;
          g_r       <= in_gradient_value;
          w_r       <= in_current_weight;
          gm_r      <= in_gradient_value[31] ? (~in_gradient_value + 32'd1) : in_gradient_value;
          wm_r      <= in_current_weight[31] ? (~in_current_weight + 32'd1) : in_current_weight;
          mod_rem_r <= '0;
          mod_cnt_r <= '0;
        end
      end
      S_MOD: begin
        mod_rem_r <= mod_nxt;
        idx_in_r  <= {idx_in_r[IDX_W-2:0], 1'b0};
        mod_cnt_r <= mod_cnt_r + 4'd1;
      end
      S_LOAD: begin
        z_old_r <= z_rdata;
        n_old_r <= n_rdata;
      end
      S_MULG: begin
        if (unit_done) begin
          n_new_r <= n_sum[N_W] ? {N_W{1'b1}} : n_sum[N_W-1:0];
        end
      end
      S_SQO: if (unit_done) s_old_r <= sq_root;
      S_SQN: if (unit_done) s_new_r <= sq_root;
      S_DSIG: if (unit_done) sigma_r <= dv_q[MA_W-1:0];
      S_MULT: begin
        if (unit_done) begin
          t_r <= (t_full > 64'h200_0000_0000) ? 42'h200_0000_0000 : t_full[41:0];
        end
      end
      S_ZUPD: begin
        z_new_r  <= z_sat;
        zm_r     <= z_mag;
        zeroed_r <= z_zeroed;
      end
      S_DDEN: begin
        if (unit_done) begin
          den_r <= {1'b0, dv_q[48:0]} + {18'h00000, l2_r};
        end
      end
      S_DMAG: begin
        if (den_r == '0) begin
          mag_r <= 33'h1_0000_0000;
        end else if (unit_done) begin
          mag_r <= (dv_q > 56'h1_0000_0000) ? 33'h1_0000_0000 : dv_q[32:0];
        end
      end
      S_FIN: begin
        if (fin_load) begin
          out_nw_r   <= nw_sat;
          out_dw_r   <= dw_sat;
          out_zero_r <= zeroed_r;
        end
      end
      default: begin
        mag_r <= mag_r;
      end
    endcase
  end

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_ZUPD);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : mod_rem_r[AW-1:0];
  assign z_wdata   = (state_r == S_CLEAR) ? '0 : z_sat;
  assign n_wdata   = (state_r == S_CLEAR) ? '0 : n_new_r;

  ftrl_ram #(.WIDTH(Z_W), .DEPTH(NUM_WEIGHTS)) u_z_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (z_wdata),
    .raddr (mod_rem_r[AW-1:0]),
    .rdata (z_rdata)
  );

  ftrl_ram #(.WIDTH(N_W), .DEPTH(NUM_WEIGHTS)) u_n_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (n_wdata),
    .raddr (mod_rem_r[AW-1:0]),
    .rdata (n_rdata)
  );

  ftrl_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  ftrl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dvd),
    .divisor  (dv_dvs),
    .done     (dv_done),
    .quotient (dv_q)
  );

  ftrl_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ml_start),
    .a     (ml_a),
    .b     (ml_b),
    .done  (ml_done),
    .prod  (ml_prod)
  );

  assign out_valid         = out_valid_r;
  assign out_new_weight    = out_nw_r;
  assign out_delta_weight  = out_dw_r;
  assign out_weight_zeroed = out_zero_r;

endmodule
